FILE: hw/rtl/base64_line_wrapped_encoder_assert.svh
// Assertion macros shared by the base64 line-wrapped encoder RTL.
// Included by files that carry concurrent checks; empty under SYNTHESIS.
`ifndef BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define B64LWE_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: check failed");
`define B64LWE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define B64LWE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define B64LWE_ASSERT(label, clk, rst, expr)
`define B64LWE_ASSERT_IMP(label, clk, rst, ante, cons)
`define B64LWE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/b64lwe_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 encoder.
// No dependencies.
`default_nettype none

package b64lwe_pkg;

   localparam logic [7:0] NL_CHAR    = 8'd10;
   localparam logic [7:0] PAD_CHAR   = 8'd61;
   localparam logic [6:0] LINE_MIN   = 7'd4;
   localparam logic [6:0] LINE_MAX   = 7'd76;
   localparam logic [6:0] LINE_RESET = 7'd60;
   localparam logic [2:0] MAX_SYMS   = 3'd4;

   // characters produced by one input byte, slot 0 goes out first
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [2:0]      count;
      logic            last;
   } bundle_type;

   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'd65 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'd71 + {2'b00, v};
      end else if (v < 6'd62) begin
         c = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'd43;
      end else begin
         c = 8'd47;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64lwe_packer.sv
// Bit packer: splits incoming bytes into 6-bit symbols, adds tail padding.
// Depends on b64lwe_pkg.
`default_nettype none

module b64lwe_packer (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     load,
   input  wire  [7:0]              data_byte,
   input  wire                     last_byte,
   output b64lwe_pkg::bundle_type  bundle
);
   import b64lwe_pkg::*;

   typedef enum logic [2:0] {
      PH_NONE = 3'b001,
      PH_TWO  = 3'b010,
      PH_FOUR = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bits_ff, bits_in;

   always_comb begin
      bundle       = '0;
      bundle.last  = last_byte;
      phase_in     = PH_NONE;
      bits_in      = 4'd0;
      unique case (phase_ff)
         PH_NONE: begin
            bundle.chars[0] = sym(data_byte[7:2]);
            if (last_byte) begin
               bundle.chars[1] = sym({data_byte[1:0], 4'b0000});
               bundle.chars[2] = PAD_CHAR;
               bundle.chars[3] = PAD_CHAR;
               bundle.count    = 3'd4;
            end else begin
               bundle.count = 3'd1;
               bits_in      = {2'b00, data_byte[1:0]};
               phase_in     = PH_TWO;
            end
         end
         PH_TWO: begin
            bundle.chars[0] = sym({bits_ff[1:0], data_byte[7:4]});
            if (last_byte) begin
               bundle.chars[1] = sym({data_byte[3:0], 2'b00});
               bundle.chars[2] = PAD_CHAR;
               bundle.count    = 3'd3;
            end else begin
               bundle.count = 3'd1;
               bits_in      = data_byte[3:0];
               phase_in     = PH_FOUR;
            end
         end
         PH_FOUR: begin
            bundle.chars[0] = sym({bits_ff, data_byte[7:6]});
            bundle.chars[1] = sym(data_byte[5:0]);
            bundle.count    = 3'd2;
         end
         default: begin
            bundle.chars[0] = sym(data_byte[7:2]);
            bundle.count    = 3'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NONE;
         bits_ff  <= 4'd0;
      end else if (load) begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/base64_line_wrapped_encoder.sv
// Base64 encoder with line wrapping: top level, character emitter, CSR.
// Depends on b64lwe_pkg, b64lwe_packer and the assertion header.
//
// Usage:
//  req_* : one raw byte per beat, req_tlast marks the last byte of a message.
//  rsp_* : one ASCII character per beat (alphabet, '=' or newline 10);
//          rsp_tlast marks the closing newline of a message.
//  csr_* : write-only line length, clamped to 4..76, reset value 60.
//          Write only while the block is idle.
// Timing: an accepted byte is split into 1 to 4 characters in the same cycle;
//  the emitter then sends one result beat per cycle while rsp is not stalled,
//  with a newline beat after every line_length characters and at the end of a
//  message. The first result is registered in the emitter and then in the rsp
//  output register. The next byte is taken in the cycle the emitter sends the
//  last beat of the current one.
// Reset clears the encoder control and line state; line length returns to 60.
// A stall on rsp holds the output register and the emitter; req waits while busy.
`default_nettype none

module base64_line_wrapped_encoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire         req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast,   // last_char
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [6:0]  csr_data
);
   import b64lwe_pkg::*;

`include "base64_line_wrapped_encoder_assert.svh"

   bundle_type      bundle;
   logic            accept;

   logic [6:0]      len_ff;
   logic            busy_ff, busy_in;
   logic [3:0][7:0] chars_ff, chars_in;
   logic [2:0]      left_ff, left_in;
   logic            nl_pend_ff, nl_pend_in;
   logic            last_item_ff, last_item_in;
   logic [6:0]      pos_ff, pos_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]      rsp_tdata_ff, rsp_tdata_in;
   logic            rsp_tlast_ff, rsp_tlast_in;

   logic            out_free, step, done, wrap;
   logic [6:0]      pos_inc;
   logic [7:0]      emit_char;
   logic            emit_last;

   assign accept = req_tvalid & req_tready;

   b64lwe_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .bundle    (bundle)
   );

   // line length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LINE_RESET;
      end else if (csr_valid) begin
         if (csr_data < LINE_MIN) begin
            len_ff <= LINE_MIN;
         end else if (csr_data > LINE_MAX) begin
            len_ff <= LINE_MAX;
         end else begin
            len_ff <= csr_data;
         end
      end
   end

   // emitter: one beat per step
   assign out_free = ~rsp_tvalid_ff | rsp_tready;
   assign step     = busy_ff & out_free;
   assign pos_inc  = pos_ff + 7'd1;
   assign wrap     = (pos_inc >= len_ff);

   always_comb begin
      emit_char  = NL_CHAR;
      emit_last  = 1'b0;
      done       = 1'b0;
      chars_in   = chars_ff;
      left_in    = left_ff;
      nl_pend_in = nl_pend_ff;
      pos_in     = pos_ff;
      priority if (nl_pend_ff) begin
         emit_last  = last_item_ff & (left_ff == 3'd0);
         done       = (left_ff == 3'd0);
         nl_pend_in = 1'b0;
         pos_in     = 7'd0;
      end else if (left_ff != 3'd0) begin
         emit_char  = chars_ff[0];
         chars_in   = {8'h00, chars_ff[3:1]};
         left_in    = left_ff - 3'd1;
         nl_pend_in = wrap;
         pos_in     = wrap ? 7'd0 : pos_inc;
         // a last item always needs a closing newline after its final char
         done       = (left_ff == 3'd1) & ~wrap & ~last_item_ff;
      end else begin
         // closing newline of a partial line
         emit_last  = 1'b1;
         done       = 1'b1;
         pos_in     = 7'd0;
      end
   end

   assign req_tready = ~busy_ff | (step & done);

   always_comb begin
      busy_in       = busy_ff;
      last_item_in  = last_item_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (step) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = emit_char;
         rsp_tlast_in  = emit_last;
         if (done) begin
            busy_in = 1'b0;
         end
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (accept) begin
         busy_in      = 1'b1;
         last_item_in = bundle.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         left_ff       <= 3'd0;
         nl_pend_ff    <= 1'b0;
         last_item_ff  <= 1'b0;
         pos_ff        <= 7'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         last_item_ff  <= last_item_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         pos_ff        <= step ? pos_in : pos_ff;
         if (accept) begin
            left_ff    <= bundle.count;
            nl_pend_ff <= 1'b0;
         end else if (step) begin
            left_ff    <= left_in;
            nl_pend_ff <= nl_pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chars_ff <= bundle.chars;
      end else if (step) begin
         chars_ff <= chars_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `B64LWE_ASSERT(a_pos_range, clock, reset, pos_ff <= LINE_MAX)
   `B64LWE_ASSERT(a_left_range, clock, reset, left_ff <= MAX_SYMS)
   `B64LWE_ASSERT_IMP(a_close_nl_only_last, clock, reset, busy_ff && left_ff == 3'd0 && !nl_pend_ff, last_item_ff)
   `B64LWE_ASSERT_IMP(a_tlast_is_nl, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == NL_CHAR)
   `B64LWE_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, busy_ff)

endmodule

`default_nettype wire

FILE: verif/base64_line_wrapped_encoder_tb.sv
// Testbench for base64_line_wrapped_encoder: random stream traffic on req/rsp,
// line-length writes between phases, and a scoreboard predicting each character.
// Depends on b64lwe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_tb;
   import b64lwe_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   class char_scoreboard;
      logic [6:0] line_len;
      logic [3:0] rem_bits;
      int unsigned rem_cnt;
      logic [6:0] line_col;
      enc_char_type expected_chars[$];
      int failures;

      function new();
         line_len = LINE_RESET;
         rem_bits = '0;
         rem_cnt = 0;
         line_col = '0;
         failures = 0;
      endfunction

      function void set_line_length(logic [6:0] v);
         if (v < LINE_MIN) line_len = LINE_MIN;
         else if (v > LINE_MAX) line_len = LINE_MAX;
         else line_len = v;
      endfunction

      function logic [7:0] b64_symbol(logic [5:0] v);
         string abc;
         abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         return abc[v];
      endfunction

      function void push_raw(logic [7:0] c);
         enc_char_type e;
         e.ch = c;
         e.last = 1'b0;
         expected_chars.push_back(e);
      endfunction

      // one line character, with a wrap newline once the line is full
      function void put_char(logic [7:0] c);
         push_raw(c);
         line_col = line_col + 7'd1;
         if (line_col >= line_len) begin
            push_raw(NL_CHAR);
            line_col = '0;
         end
      endfunction

      function void encode_byte(logic [7:0] d, logic last);
         logic [11:0] acc;
         int unsigned cnt;
         enc_char_type tail;
         acc = {rem_bits, d};
         cnt = rem_cnt + 8;
         while (cnt >= 6) begin
            cnt -= 6;
            put_char(b64_symbol(6'(acc >> cnt)));
         end
         rem_cnt = cnt;
         rem_bits = 4'(acc & ((12'd1 << cnt) - 12'd1));
         if (last) begin
            if (rem_cnt == 2) begin
               put_char(b64_symbol({rem_bits[1:0], 4'b0000}));
               put_char(PAD_CHAR);
               put_char(PAD_CHAR);
            end else if (rem_cnt == 4) begin
               put_char(b64_symbol({rem_bits, 2'b00}));
               put_char(PAD_CHAR);
            end
            if (line_col != 0) push_raw(NL_CHAR);
            tail = expected_chars.pop_back();
            tail.last = 1'b1;
            expected_chars.push_back(tail);
            rem_bits = '0;
            rem_cnt = 0;
            line_col = '0;
         end
      endfunction

      function void report(string what, logic [8:0] want, logic [8:0] got);
         failures++;
         if (failures <= 10)
            $display("%0t %s: expected char %h last %b, got char %h last %b",
                     $realtime, what, want[8:1], want[0], got[8:1], got[0]);
      endfunction

      function void check_char(logic [7:0] ch, logic last);
         enc_char_type want;
         if (expected_chars.size() == 0) begin
            report("unexpected beat", 'x, {ch, last});
            return;
         end
         want = expected_chars.pop_front();
         if (want.ch !== ch || want.last !== last)
            report("mismatch", want, {ch, last});
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] data_byte
   logic       req_tlast = 1'b0; // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [7:0] out_char
   logic       rsp_tlast;        // last_char
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data = '0;

   logic steady = 1'b0;
   int   holds_asked = 0;
   int   bytes_sent = 0;
   int   msg_left = 0;
   char_scoreboard board = new();

   base64_line_wrapped_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver: checks every beat, random backpressure, long hold-offs on request
   initial begin : rsp_side
      int hold_left;
      int holds_taken;
      hold_left = 0;
      holds_taken = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_char(rsp_tdata, rsp_tlast);
         if (holds_taken != holds_asked) begin
            holds_taken++;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 27);
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic l);
      if (!steady) begin
         while ($urandom_range(99) < 27) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.encode_byte(d, l);
      bytes_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_line_length(input logic [6:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_line_length(v);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int phase;
      int budget;
      logic [6:0] len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // remainder of 2, 4 and 0 bits at message end: "==", "=" and no pad
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      // sixteen characters of a line at length 60, then drop the length below the column
      repeat (12) send_byte(8'($urandom_range(255)), 1'b0);
      drain();
      write_line_length(7'd3);
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b1);
      // four characters fill a line of four: wrap newline closes the message
      drain();
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);

      phase = 0;
      while (bytes_sent < 280) begin
         drain();
         case (phase % 8)
            0: len = 7'd127;
            1: len = LINE_MIN;
            2: len = 7'($urandom_range(4, 20));
            3: len = 7'd0;
            4: len = LINE_MAX;
            5: len = 7'd77;
            6: len = 7'($urandom_range(127));
            default: len = 7'($urandom_range(4, 76));
         endcase
         write_line_length(len);
         steady <= (phase == 1);
         if (phase == 2) holds_asked <= holds_asked + 1;
         budget = $urandom_range(25, 45);
         repeat (budget) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(99) < 80) ? $urandom_range(1, 6)
                                                   : $urandom_range(7, 70);
            send_byte(8'($urandom_range(255)), msg_left == 1);
            msg_left--;
         end
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: base64_line_wrapped_encoder.f
+incdir+hw/rtl
hw/rtl/b64lwe_pkg.sv
hw/rtl/b64lwe_packer.sv
hw/rtl/base64_line_wrapped_encoder.sv
verif/base64_line_wrapped_encoder_tb.sv
